// ===== hw/rtl/dnc_pkg.sv =====
// ----------------------------------------------------------------------------
// dnc_pkg: shared types and constants for the dominant nibble colour block
// Nibble and counter widths, the number of bins, and the token that carries
// the running best bin along the row of counting cells.
// ----------------------------------------------------------------------------
package dnc_pkg;

  localparam int unsigned NIB_W    = 4;
  localparam int unsigned NIBS     = 4;
  localparam int unsigned WORD_W   = NIB_W * NIBS;
  localparam int unsigned NUM_BINS = 15;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned HIT_W    = $clog2(NIBS + 1);

  localparam logic [CNT_W-1:0] CNT_MAX     = '1;
  localparam logic [NIB_W-1:0] DEFAULT_IDX = NIB_W'(1);

  typedef struct packed {
    logic             valid;
    logic [NIB_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
  } tok_t;

endpackage

// ===== hw/rtl/dnc_if.sv =====
// ----------------------------------------------------------------------------
// dnc_if: request channels of the dominant nibble colour block
// One interface for pixel words in and one for colour results out.
// ----------------------------------------------------------------------------
interface dnc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_word;
  logic        last;

  modport source (output valid, output pixel_word, output last, input ready);
  modport sink   (input valid, input pixel_word, input last, output ready);
endinterface

interface dnc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] colour_index;

  modport source (output valid, output colour_index, input ready);
  modport sink   (input valid, input colour_index, output ready);
endinterface

// ===== hw/rtl/dnc_cell.sv =====
// ----------------------------------------------------------------------------
// dnc_cell: one histogram bin of the dominant nibble colour block
// Counts matching nibbles with saturation, and during the scan compares its
// count against the passing token, then clears itself.
// ----------------------------------------------------------------------------
module dnc_cell import dnc_pkg::*; #(
  parameter int unsigned BIN_IDX = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              count_en,
  input  logic [WORD_W-1:0] pixel_word,
  input  logic              advance,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  localparam logic [NIB_W-1:0] MY_IDX = NIB_W'(BIN_IDX);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [HIT_W-1:0] hits;
  logic [CNT_W:0]   sum;

  always_comb begin
    hits = '0;
    for (int k = 0; k < NIBS; k++) begin
      if (pixel_word[k*NIB_W +: NIB_W] == MY_IDX) begin
        hits = hits + HIT_W'(1);
      end
    end
    sum = {1'b0, count} + (CNT_W+1)'(hits);
    if (sum > {1'b0, CNT_MAX}) begin
      count_next = CNT_MAX;
    end else begin
      count_next = sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      if (advance && tok_in.valid) begin
        count <= '0;
      end else if (count_en) begin
        count <= count_next;
      end
      if (advance) begin
        tok_out.valid <= tok_in.valid;
      end
    end
    // Strictly greater keeps the earlier, lower index on a tie.
    if (advance) begin
      if (count > tok_in.cnt) begin
        tok_out.idx <= MY_IDX;
        tok_out.cnt <= count;
      end else begin
        tok_out.idx <= tok_in.idx;
        tok_out.cnt <= tok_in.cnt;
      end
    end
  end

endmodule

// ===== hw/rtl/dominant_nibble_colour.sv =====
// Scan path: a word marked last launches a token from the start register; the token
//   then passes through each of the 15 cells of the row and into the output register.
//   The whole row holds while the token at the tail waits for the output register.
// Throughput: one word per cycle while a run is counted; after a last word the
//   input is held off until the scan token leaves the row, later while the previous result waits.
// Reset: synchronous; all bin counts clear, no scan is pending, no result.
// ----------------------------------------------------------------------------
// dominant_nibble_colour: most frequent nonzero 4-bit palette index in a run
// A row of bin cells counts nibbles; a token walks the row to find the mode.
// ----------------------------------------------------------------------------
module dominant_nibble_colour import dnc_pkg::*; (
  input logic      clk,
  input logic      rst,
  dnc_in_if.sink   pixels,
  dnc_out_if.source result
);

  tok_t              chain [NUM_BINS+1];
  logic [NUM_BINS:0] chain_valid;
  logic              start_valid;
  logic              busy;
  logic              accept;
  logic              advance;
  logic              out_load;
  logic              out_valid;
  logic [NIB_W-1:0]  out_idx;

  assign chain[0].valid = start_valid;
  assign chain[0].idx   = DEFAULT_IDX;
  assign chain[0].cnt   = '0;

  always_comb begin
    for (int i = 0; i <= NUM_BINS; i++) begin
      chain_valid[i] = chain[i].valid;
    end
  end

  assign busy     = |chain_valid;
  assign accept   = pixels.valid && pixels.ready;
  assign out_load = chain[NUM_BINS].valid && (!out_valid || result.ready);
  // Only a waiting token at the tail stalls the row, and then every cell holds.
  assign advance  = !(chain[NUM_BINS].valid && !out_load);

  assign pixels.ready        = !busy;
  assign result.valid        = out_valid;
  assign result.colour_index = out_idx;

  for (genvar g = 0; g < NUM_BINS; g++) begin : g_bin
    dnc_cell #(.BIN_IDX(g + 1)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .count_en   (accept),
      .pixel_word (pixels.pixel_word),
      .advance    (advance),
      .tok_in     (chain[g]),
      .tok_out    (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept && pixels.last) begin
        start_valid <= 1'b1;
      end else if (advance) begin
        start_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx <= chain[NUM_BINS].idx;
    end
  end

endmodule

// ===== hw/rtl/dnc_checker.sv =====
// ----------------------------------------------------------------------------
// dnc_checker: port-level checks for the dominant nibble colour block
// Watches the request channels of the top level over time.
// ----------------------------------------------------------------------------
module dnc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] colour_index
);

  // A result is never the transparent index.
  a_idx_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> colour_index != 4'd0)
    else $error("result carries index zero");

  // The scan holds off new words right after a last word.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("word accepted during scan");

  // A word inside a run never stalls the input.
  a_open_in_run: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_last) |=> in_ready)
    else $error("input stalled inside a run");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(colour_index)))
    else $error("stalled result changed");

endmodule

bind dominant_nibble_colour dnc_checker u_dnc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (pixels.valid),
  .in_ready     (pixels.ready),
  .in_last      (pixels.last),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .colour_index (result.colour_index)
);
